FILE: hw/rtl/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg: shared types and constants for the Miller-Rabin primality tester
// Base table, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int unsigned NumBitsDef  = 64;
  localparam int unsigned NumBasesDef = 12;
  localparam int unsigned BaseTblLen  = 12;
  localparam int unsigned BaseW       = 6;

  // Witness bases, first NUM_BASES of them are used
  function automatic logic [BaseW-1:0] base_at(input logic [3:0] idx);
    logic [BaseW-1:0] b;
    begin
      case (idx)
        4'd0:    b = 6'd2;
        4'd1:    b = 6'd3;
        4'd2:    b = 6'd5;
        4'd3:    b = 6'd7;
        4'd4:    b = 6'd11;
        4'd5:    b = 6'd13;
        4'd6:    b = 6'd17;
        4'd7:    b = 6'd19;
        4'd8:    b = 6'd23;
        4'd9:    b = 6'd29;
        4'd10:   b = 6'd31;
        4'd11:   b = 6'd37;
        default: b = 6'd2;
      endcase
      return b;
    end
  endfunction

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture candidate, clear base index
    OP_MODSTART,  // start remainder n mod a, set d = n-1 and r = 0
    OP_MODSTEP,   // one bit of n mod a
    OP_SHIFTD,    // d >>= 1, r++
    OP_POWINIT,   // x = 1, y = a, e = d
    OP_YREDUCE,   // y -= n, brings a base above n back below n
    OP_MULSTART,  // start product (x*y or y*y or x*x)
    OP_MULSTEP,   // one bit of a shift-and-add product
    OP_MULDONE,   // write product result back
    OP_EXPSHIFT,  // e >>= 1
    OP_SQSTART,   // unused; squaring starts via OP_MULSTART with MSEL_X_X
    OP_NEXTBASE   // advance base index
  } mrpt_op_e;

  typedef enum logic [1:0] {
    MSEL_ACC_Y,
    MSEL_Y_Y,
    MSEL_X_X
  } mrpt_msel_e;

  typedef struct packed {
    mrpt_op_e   op;
    mrpt_msel_e msel;
    logic       sq_inc;
  } mrpt_cmd_t;

  typedef struct packed {
    logic below2;      // n < 2
    logic mod_done;    // remainder finished
    logic mod_zero;    // n mod a == 0
    logic n_eq_a;      // n == a
    logic d_even;      // d even and nonzero, r < bits
    logic y_ge_n;      // y not yet below n
    logic mul_done;    // product finished
    logic e_zero;      // exponent exhausted
    logic e_lsb;       // exponent low bit
    logic x_one;       // x == 1
    logic x_nm1;       // x == n-1
    logic sq_more;     // k < r
    logic last_base;   // base index is the last one
  } mrpt_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHK,
    ST_MOD,
    ST_MODCHK,
    ST_DSPLIT,
    ST_POWINIT,
    ST_YRED,
    ST_PEXP,
    ST_PMUL_A,
    ST_PMUL_A_RUN,
    ST_PMUL_B,
    ST_PMUL_B_RUN,
    ST_PSHIFT,
    ST_XCHK,
    ST_SQ,
    ST_SQ_RUN,
    ST_SQCHK,
    ST_PASS,
    ST_OUT_T,
    ST_OUT_F
  } mrpt_state_e;

endpackage

FILE: hw/rtl/mrpt_datapath.sv
// ----------------------------------------------------------------------------
// mrpt_datapath: operand registers and bit-serial arithmetic
// Holds n, d, r, x, y, e; bit-serial remainder and modular product units.
// ----------------------------------------------------------------------------
module mrpt_datapath #(
  parameter int unsigned NumBits  = mrpt_pkg::NumBitsDef,
  parameter int unsigned NumBases = mrpt_pkg::NumBasesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [NumBits-1:0]  cand_i,
  input  mrpt_pkg::mrpt_cmd_t cmd_i,
  output mrpt_pkg::mrpt_sts_t sts_o
);
  import mrpt_pkg::*;

  localparam int unsigned CntW = $clog2(NumBits + 1);
  localparam int unsigned IdxW = $clog2(NumBits);

  logic [NumBits-1:0] n_q, d_q, x_q, y_q, e_q;
  logic [CntW-1:0]    r_q, k_q, bit_q;
  logic [3:0]         bidx_q;
  logic [BaseW-1:0]   rem_q;
  logic [NumBits-1:0] macc_q, mx_q, my_q;
  logic               busy_q;

  logic [BaseW-1:0]   base_w;
  logic [NumBits-1:0] base_ext, nm1;
  logic [IdxW-1:0]    nbit_idx;
  logic [BaseW:0]     rem_sh;
  logic [NumBits:0]   sum_a, sum_x;
  logic [NumBits-1:0] madd, mdbl;

  assign base_w   = base_at(bidx_q);
  assign base_ext = NumBits'(base_w);
  assign nm1      = n_q - NumBits'(1);

  // Next remainder bit: rem = 2*rem + n[bit], minus a if it reaches a
  assign nbit_idx = IdxW'(bit_q - CntW'(1));
  assign rem_sh   = {rem_q, n_q[nbit_idx]};

  // Modular add helpers (operands already below n)
  assign sum_a = {1'b0, macc_q} + {1'b0, mx_q};
  assign sum_x = {1'b0, mx_q} + {1'b0, mx_q};
  assign madd  = (sum_a >= {1'b0, n_q}) ? NumBits'(sum_a - {1'b0, n_q}) : sum_a[NumBits-1:0];
  assign mdbl  = (sum_x >= {1'b0, n_q}) ? NumBits'(sum_x - {1'b0, n_q}) : sum_x[NumBits-1:0];

  // Register updates driven by the controller's command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bidx_q <= '0;
      bit_q  <= '0;
      r_q    <= '0;
      k_q    <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          n_q    <= cand_i;
          bidx_q <= '0;
        end
        OP_MODSTART: begin
          rem_q  <= '0;
          bit_q  <= CntW'(NumBits);
          busy_q <= 1'b1;
          d_q    <= nm1;
          r_q    <= '0;
        end
        OP_MODSTEP: begin
          rem_q <= (rem_sh >= {1'b0, base_w}) ? BaseW'(rem_sh - {1'b0, base_w})
                                              : rem_sh[BaseW-1:0];
          bit_q <= bit_q - CntW'(1);
          if (bit_q == CntW'(1)) busy_q <= 1'b0;
        end
        OP_SHIFTD: begin
          d_q <= d_q >> 1;
          r_q <= r_q + CntW'(1);
        end
        OP_POWINIT: begin
          x_q <= (n_q == NumBits'(1)) ? '0 : NumBits'(1);
          y_q <= base_ext;
          e_q <= d_q;
          k_q <= CntW'(1);
        end
        // Base above a small n: subtract n until it is below n
        OP_YREDUCE: y_q <= y_q - n_q;
        OP_MULSTART: begin
          macc_q <= '0;
          bit_q  <= CntW'(NumBits);
          busy_q <= 1'b1;
          case (cmd_i.msel)
            MSEL_ACC_Y: begin mx_q <= x_q; my_q <= y_q; end
            MSEL_Y_Y:   begin mx_q <= y_q; my_q <= y_q; end
            default:    begin mx_q <= x_q; my_q <= x_q; end
          endcase
        end
        OP_MULSTEP: begin
          if (my_q[0]) macc_q <= madd;
          mx_q  <= mdbl;
          my_q  <= my_q >> 1;
          bit_q <= bit_q - CntW'(1);
          if (bit_q == CntW'(1)) busy_q <= 1'b0;
        end
        OP_MULDONE: begin
          if (cmd_i.msel == MSEL_Y_Y) y_q <= macc_q;
          else x_q <= macc_q;
          if (cmd_i.sq_inc) k_q <= k_q + CntW'(1);
        end
        OP_EXPSHIFT: e_q <= e_q >> 1;
        OP_NEXTBASE: bidx_q <= bidx_q + 4'd1;
        default: ;
      endcase
    end
  end

  // Status back to the controller
  always_comb begin
    sts_o.below2    = (n_q < NumBits'(2));
    sts_o.mod_done  = !busy_q;
    sts_o.mod_zero  = (rem_q == '0);
    sts_o.n_eq_a    = (n_q == base_ext);
    sts_o.d_even    = (d_q != '0) && !d_q[0] && (r_q < CntW'(NumBits));
    sts_o.y_ge_n    = (y_q >= n_q);
    sts_o.mul_done  = !busy_q;
    sts_o.e_zero    = (e_q == '0);
    sts_o.e_lsb     = e_q[0];
    sts_o.x_one     = (x_q == NumBits'(1));
    sts_o.x_nm1     = (x_q == nm1);
    sts_o.sq_more   = (k_q < r_q);
    sts_o.last_base = (bidx_q == 4'(NumBases - 1));
  end

endmodule

FILE: hw/rtl/mrpt_ctrl.sv
// ----------------------------------------------------------------------------
// mrpt_ctrl: sequencer for the Miller-Rabin test
// Walks the bases, the exponentiation and the squaring loop; owns handshakes.
// ----------------------------------------------------------------------------
module mrpt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                prime_flag_o,
  input  mrpt_pkg::mrpt_sts_t sts_i,
  output mrpt_pkg::mrpt_cmd_t cmd_o
);
  import mrpt_pkg::*;

  mrpt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD:       state_d = sts_i.below2 ? ST_OUT_F : ST_CHK;
      ST_CHK:        state_d = ST_MOD;
      ST_MOD:        if (sts_i.mod_done) state_d = ST_MODCHK;
      ST_MODCHK: begin
        if (sts_i.mod_zero) state_d = sts_i.n_eq_a ? ST_PASS : ST_OUT_F;
        else                state_d = ST_DSPLIT;
      end
      ST_DSPLIT:     if (!sts_i.d_even) state_d = ST_POWINIT;
      ST_POWINIT:    state_d = ST_YRED;
      ST_YRED:       if (!sts_i.y_ge_n) state_d = ST_PEXP;
      ST_PEXP: begin
        if (sts_i.e_zero)     state_d = ST_XCHK;
        else if (sts_i.e_lsb) state_d = ST_PMUL_A;
        else                  state_d = ST_PMUL_B;
      end
      ST_PMUL_A:     state_d = ST_PMUL_A_RUN;
      ST_PMUL_A_RUN: if (sts_i.mul_done) state_d = ST_PMUL_B;
      ST_PMUL_B:     state_d = ST_PMUL_B_RUN;
      ST_PMUL_B_RUN: if (sts_i.mul_done) state_d = ST_PSHIFT;
      ST_PSHIFT:     state_d = ST_PEXP;
      ST_XCHK: begin
        if (sts_i.x_one || sts_i.x_nm1) state_d = ST_PASS;
        else if (sts_i.sq_more)         state_d = ST_SQ;
        else                            state_d = ST_OUT_F;
      end
      ST_SQ:         state_d = ST_SQ_RUN;
      ST_SQ_RUN:     if (sts_i.mul_done) state_d = ST_SQCHK;
      ST_SQCHK: begin
        if (sts_i.x_nm1)        state_d = ST_PASS;
        else if (sts_i.sq_more) state_d = ST_SQ;
        else                    state_d = ST_OUT_F;
      end
      ST_PASS:       state_d = sts_i.last_base ? ST_OUT_T : ST_CHK;
      ST_OUT_T,
      ST_OUT_F:      if (!out_stall_i) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd_o.op     = OP_NONE;
    cmd_o.msel   = MSEL_ACC_Y;
    cmd_o.sq_inc = 1'b0;
    in_stall_o   = (state_q != ST_IDLE);
    out_valid_o  = (state_q == ST_OUT_T) || (state_q == ST_OUT_F);
    prime_flag_o = (state_q == ST_OUT_T);
    case (state_q)
      ST_IDLE:    if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_CHK:     cmd_o.op = OP_MODSTART;
      ST_MOD:     if (!sts_i.mod_done) cmd_o.op = OP_MODSTEP;
      ST_DSPLIT:  if (sts_i.d_even) cmd_o.op = OP_SHIFTD;
      ST_POWINIT: cmd_o.op = OP_POWINIT;
      ST_YRED:    if (sts_i.y_ge_n) cmd_o.op = OP_YREDUCE;
      ST_PMUL_A:  begin cmd_o.op = OP_MULSTART; cmd_o.msel = MSEL_ACC_Y; end
      ST_PMUL_A_RUN: begin
        cmd_o.msel = MSEL_ACC_Y;
        cmd_o.op   = sts_i.mul_done ? OP_MULDONE : OP_MULSTEP;
      end
      ST_PMUL_B:  begin cmd_o.op = OP_MULSTART; cmd_o.msel = MSEL_Y_Y; end
      ST_PMUL_B_RUN: begin
        cmd_o.msel = MSEL_Y_Y;
        cmd_o.op   = sts_i.mul_done ? OP_MULDONE : OP_MULSTEP;
      end
      ST_PSHIFT:  cmd_o.op = OP_EXPSHIFT;
      ST_SQ:      begin cmd_o.op = OP_MULSTART; cmd_o.msel = MSEL_X_X; end
      ST_SQ_RUN: begin
        cmd_o.msel   = MSEL_X_X;
        cmd_o.op     = sts_i.mul_done ? OP_MULDONE : OP_MULSTEP;
        cmd_o.sq_inc = sts_i.mul_done;
      end
      ST_PASS:    cmd_o.op = OP_NEXTBASE;
      default:    ;
    endcase
  end

endmodule

FILE: hw/rtl/miller_rabin_primality_test.sv
// ----------------------------------------------------------------------------
// miller_rabin_primality_test: deterministic 64-bit Miller-Rabin tester
// Controller plus bit-serial datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: candidate_i with in_valid_i / in_stall_o. A request is
//   taken when valid is high and stall is low; stall is high while a
//   candidate is in work or its answer waits.
//   Output channel: prime_flag_o with out_valid_o / out_stall_i. The answer
//   holds until taken; a stalled answer just waits, nothing is lost.
//   Run time: each modular product runs one bit per cycle, and each base
//   needs up to 2*NUM_BITS products plus a bit-serial remainder, n mod a.
//   Even composites and numbers below two finish at or before the first
//   base. The serial shift-and-add product unit dominates the run time.
//   One candidate at a time. Reset returns the controller to idle; no
//   stored state survives between candidates.
// ----------------------------------------------------------------------------
module miller_rabin_primality_test #(
  parameter int unsigned NUM_BITS  = mrpt_pkg::NumBitsDef,
  parameter int unsigned NUM_BASES = mrpt_pkg::NumBasesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [NUM_BITS-1:0] candidate_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                prime_flag_o
);
  import mrpt_pkg::*;

  mrpt_cmd_t cmd;
  mrpt_sts_t sts;

  // Sequencer
  mrpt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .prime_flag_o, .sts_i(sts), .cmd_o(cmd)
  );

  // Arithmetic
  mrpt_datapath #(.NumBits(NUM_BITS), .NumBases(NUM_BASES)) u_dp (
    .clk_i, .rst_ni, .cand_i(candidate_i), .cmd_i(cmd), .sts_o(sts)
  );

endmodule

FILE: hw/rtl/mrpt_checker.sv
// ----------------------------------------------------------------------------
// mrpt_checker: port-level checks for the primality tester
// One request in flight at a time, and a stalled answer holds.
// ----------------------------------------------------------------------------
module mrpt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic prime_flag_o
);
  // Input is blocked while an answer is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during answer");

  // After a request is taken the input closes
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("input not closed");

  // An answer taken frees the input next cycle
  a_free_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o && !in_stall_o)
    else $error("not idle after answer");

  // Stalled answer holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(prime_flag_o))
    else $error("answer changed under stall");

endmodule

bind miller_rabin_primality_test mrpt_checker u_mrpt_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .prime_flag_o
);
